/* rtl/core/pics_pkg.sv */
// Package: shared constants and transaction types for the Poisson inverse-CDF sampler.
package pics_pkg;

  localparam int unsigned MAX_COUNT = 100;
  localparam int unsigned LAM_W     = 21;
  localparam int unsigned U_W       = 32;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned Q_W       = 64;

  // round(exp(-2^-16) * 2^64)
  localparam logic [Q_W-1:0] EXP_SEED = 64'hFFFF_0000_7FFF_D555;

  typedef struct packed {
    logic [LAM_W-1:0] lambda_mean;
    logic [U_W-1:0]   uniform_value;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] sample_count;
    logic             beyond_table;
  } out_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic       en;
    logic       clear;
    logic [1:0] sel;
  } mac_ctrl_t;

endpackage

/* rtl/core/pics_mac.sv */
// Shared 32x32 multiplier, 128-bit acc, one partial product per enabled cycle.
module pics_mac (
  input  logic                clk,
  input  pics_pkg::mac_ctrl_t ctrl,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  output logic [127:0]        acc
);

  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  prod;
  logic [127:0] prod_sh;

  assign a_part = ctrl.sel[0] ? a[63:32] : a[31:0];
  assign b_part = ctrl.sel[1] ? b[63:32] : b[31:0];
  assign prod   = 64'(a_part) * 64'(b_part);

  always_comb begin
    prod_sh = {64'b0, prod};
    case (ctrl.sel)
      2'b00:   prod_sh = {64'b0, prod};
      2'b11:   prod_sh = {prod, 64'b0};
      default: prod_sh = {32'b0, prod, 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= ctrl.clear ? prod_sh : acc + prod_sh;
    end
  end

endmodule

/* rtl/core/poisson_inverse_cdf_sampler_top.sv */
// Top level: Poisson inverse-CDF sampler built on one shared multiply-accumulate unit.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (lambda_mean, uniform_value)
//  out     | output    | out_valid/out_stall| out_data (sample_count, beyond_table)
//
// One transaction at a time; in_stall is high from acceptance until the result is taken.
// exp(-lambda): one step for each of lambda's 21 bits (MAC square of p, write-back),
// plus a MAC multiply and a write-back of e for each set bit after the first.
// Each count term: MAC multiply, load, 9 divide steps of 8 quotient bits, add, compare.
// The time to a result is set by lambda's bits and the count.
// Reset (rst, synchronous) clears the sequencer and out_valid; a stalled result holds.
module poisson_inverse_cdf_sampler_top #(
  parameter int unsigned MAX_COUNT = pics_pkg::MAX_COUNT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pics_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pics_pkg::out_t out_data
);

  localparam int unsigned KW = $clog2(MAX_COUNT + 1);
  localparam logic [KW-1:0] K_MAX = KW'(MAX_COUNT);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_EXPB = 12'b0000_0000_0010,
    S_EMUL = 12'b0000_0000_0100,
    S_EWB  = 12'b0000_0000_1000,
    S_PSQ  = 12'b0000_0001_0000,
    S_PWB  = 12'b0000_0010_0000,
    S_CMP  = 12'b0000_0100_0000,
    S_TMUL = 12'b0000_1000_0000,
    S_TLD  = 12'b0001_0000_0000,
    S_TDIV = 12'b0010_0000_0000,
    S_TADD = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic [pics_pkg::LAM_W-1:0] lam;
  logic [pics_pkg::U_W-1:0]   u;
  logic [4:0]                 bitn;
  logic                       any;
  logic [63:0]                e;
  logic [63:0]                p;
  logic [63:0]                t;
  logic [63:0]                sum;
  logic [KW-1:0]              k;
  logic [1:0]                 j;
  logic [3:0]                 dcnt;
  logic [71:0]                dv;
  logic [71:0]                q;
  logic [KW-1:0]              rem;

  // shared MAC
  pics_pkg::mac_ctrl_t mac_ctrl;
  logic [63:0]         mac_a;
  logic [63:0]         mac_b;
  logic [127:0]        acc;

  always_comb begin
    mac_ctrl.en    = (state == S_EMUL) || (state == S_PSQ) || (state == S_TMUL);
    mac_ctrl.clear = (j == 2'd0);
    mac_ctrl.sel   = j;
    mac_a = p;
    mac_b = p;
    unique case (state)
      S_EMUL:  begin mac_a = e; mac_b = p; end
      S_TMUL:  begin mac_a = t; mac_b = 64'(lam); end
      default: begin mac_a = p; mac_b = p; end
    endcase
  end

  pics_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  // divide step: eight quotient bits per cycle, divisor k
  logic [KW-1:0] rem_next;
  logic [7:0]    qbits;
  always_comb begin
    logic [KW:0] r;
    r = {1'b0, rem};
    for (int i = 7; i >= 0; i--) begin
      r = {r[KW-1:0], dv[64+i]};
      if (r >= {1'b0, k}) begin
        r = r - {1'b0, k};
        qbits[i] = 1'b1;
      end else begin
        qbits[i] = 1'b0;
      end
    end
    rem_next = r[KW-1:0];
  end

  logic [63:0] t_next;
  logic [64:0] sum_wide;
  assign t_next   = (|q[71:64]) ? '1 : q[63:0];
  assign sum_wide = {1'b0, sum} + {1'b0, t_next};

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      j         <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            lam   <= in_data.lambda_mean;
            u     <= in_data.uniform_value;
            bitn  <= 5'd0;
            any   <= 1'b0;
            p     <= pics_pkg::EXP_SEED;
            j     <= 2'd0;
            state <= S_EXPB;
          end
        end
        S_EXPB: begin
          if (lam[bitn] && any) begin
            state <= S_EMUL;
          end else begin
            if (lam[bitn]) begin
              e   <= p;
              any <= 1'b1;
            end
            state <= S_PSQ;
          end
        end
        S_EMUL: begin
          j <= j + 2'd1;
          if (j == 2'd3) state <= S_EWB;
        end
        S_EWB: begin
          e     <= acc[127:64];
          state <= S_PSQ;
        end
        S_PSQ: begin
          j <= j + 2'd1;
          if (j == 2'd3) state <= S_PWB;
        end
        S_PWB: begin
          p <= acc[127:64];
          if (bitn == 5'(pics_pkg::LAM_W - 1)) begin
            t     <= any ? e : '1;
            sum   <= any ? e : '1;
            k     <= '0;
            state <= S_CMP;
          end else begin
            bitn  <= bitn + 5'd1;
            state <= S_EXPB;
          end
        end
        S_CMP: begin
          if ({u, 32'b0} < sum) begin
            out_data.sample_count <= pics_pkg::CNT_W'(k);
            out_data.beyond_table <= 1'b0;
            out_valid             <= 1'b1;
            state                 <= S_DONE;
          end else if (k == K_MAX) begin
            out_data.sample_count <= '0;
            out_data.beyond_table <= 1'b1;
            out_valid             <= 1'b1;
            state                 <= S_DONE;
          end else begin
            k     <= k + KW'(1);
            state <= S_TMUL;
          end
        end
        S_TMUL: begin
          j <= j + 2'd1;
          if (j == 2'd3) state <= S_TLD;
        end
        S_TLD: begin
          // drop the 16 fraction bits of lambda first; floor is unchanged
          dv    <= {3'b0, acc[84:16]};
          rem   <= '0;
          dcnt  <= 4'd0;
          state <= S_TDIV;
        end
        S_TDIV: begin
          dv   <= {dv[63:0], 8'b0};
          q    <= {q[63:0], qbits};
          rem  <= rem_next;
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd8) state <= S_TADD;
        end
        S_TADD: begin
          t     <= t_next;
          sum   <= sum_wide[64] ? '1 : sum_wide[63:0];
          state <= S_CMP;
        end
        S_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/pics_checker.sv */
// Checker: port-level properties of the sampler, bound to the top level.
module pics_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input pics_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("ready straight after an accepted transaction");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.beyond_table |-> out_data.sample_count == '0)
    else $error("beyond_table with non-zero count");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind poisson_inverse_cdf_sampler_top pics_checker u_pics_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/testbench.sv */
// Testbench for the Poisson inverse-CDF sampler: queue-fed driver, monitor and predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LIMIT_CYCLES = 12_000_000;
  localparam int unsigned N_RANDOM     = 1200;
  localparam int unsigned DRAIN_CYCLES = 2000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  pics_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  pics_pkg::out_t out_data;

  poisson_inverse_cdf_sampler_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pics_pkg::in_t  pending_items[$];
  pics_pkg::out_t expected_samples[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   beyond_seen = 0;
  int   cycle_count = 0;

  // Idling mode: 0 sender 21 / receiver 48, 1 swapped, 2 no idling.
  int   idle_mode = 0;
  bit   hold_receiver = 1'b0;
  int   hold_cycles = 0;

  // ---------------------------------------------------------------------
  // Predictor: Q0.64 arithmetic as the block computes it.
  // ---------------------------------------------------------------------
  function automatic logic [63:0] q64_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return full[127:64];
  endfunction

  function automatic logic [63:0] exp_neg_lambda(logic [pics_pkg::LAM_W-1:0] lam);
    logic [63:0] p;
    logic [63:0] e;
    bit any;
    p = pics_pkg::EXP_SEED;
    e = '0;
    any = 1'b0;
    for (int b = 0; b < pics_pkg::LAM_W; b++) begin
      if (lam[b]) begin
        e = any ? q64_product(e, p) : p;
        any = 1'b1;
      end
      p = q64_product(p, p);
    end
    return any ? e : '1;
  endfunction

  function automatic pics_pkg::out_t predict_sample(pics_pkg::in_t item);
    logic [63:0]    term;
    logic [63:0]    cum;
    logic [63:0]    u64;
    logic [127:0]   wide;
    logic [64:0]    s65;
    pics_pkg::out_t res;
    bit             hit;
    int             found;
    term = exp_neg_lambda(item.lambda_mean);
    cum = term;
    u64 = {item.uniform_value, 32'd0};
    hit = u64 < cum;
    found = 0;
    for (int k = 1; k <= pics_pkg::MAX_COUNT && !hit; k++) begin
      wide = ({64'd0, term} * {107'd0, item.lambda_mean}) / ({121'd0, 7'(k)} << 16);
      term = (wide[127:64] != 0) ? '1 : wide[63:0];
      s65 = {1'b0, cum} + {1'b0, term};
      cum = s65[64] ? '1 : s65[63:0];
      if (u64 < cum) begin
        hit = 1'b1;
        found = k;
      end
    end
    res.sample_count = hit ? found[pics_pkg::CNT_W-1:0] : '0;
    res.beyond_table = !hit;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %0s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers items from the pending queue; valid held while stalled.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_samples.insert(expected_samples.size(), predict_sample(in_data));
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction unchanged
      end else if (pending_items.size() != 0 &&
                   !(idle_mode == 0 && $urandom_range(99) < 21) &&
                   !(idle_mode == 1 && $urandom_range(99) < 48)) begin
        in_valid <= 1'b1;
        in_data  <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_receiver) begin
      hold_cycles <= 3000;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compares each accepted result with the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected transaction", out_data.sample_count, -1);
        end else begin
          pics_pkg::out_t want;
          want = expected_samples.pop_front();
          if (out_data.sample_count !== want.sample_count)
            report_mismatch("sample_count", out_data.sample_count, want.sample_count);
          if (out_data.beyond_table !== want.beyond_table)
            report_mismatch("beyond_table", out_data.beyond_table, want.beyond_table);
          if (want.beyond_table) beyond_seen++;
        end
      end
      if (hold_cycles > 0 || hold_receiver) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= (idle_mode == 0) ? ($urandom_range(99) < 48) :
                     (idle_mode == 1) ? ($urandom_range(99) < 21) : 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** poisson_inverse_cdf_sampler_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic pics_pkg::in_t make_item(logic [pics_pkg::LAM_W-1:0] lam,
                                              logic [pics_pkg::U_W-1:0] u);
    pics_pkg::in_t it;
    it.lambda_mean = lam;
    it.uniform_value = u;
    return it;
  endfunction

  task automatic queue_item(pics_pkg::in_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int lam;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero mean, extremes of range, full 21 bits, u extremes
    queue_item(make_item(21'd0, 32'd0));
    queue_item(make_item(21'd0, 32'hFFFF_FFFF));
    queue_item(make_item(21'd1, 32'd0));
    queue_item(make_item(21'd1, 32'hFFFF_FFFF));
    queue_item(make_item(21'd65536, 32'h8000_0000));
    queue_item(make_item(21'd65536, 32'hFFFF_FFFF));
    queue_item(make_item(21'd1572864, 32'd0));
    queue_item(make_item(21'd1572864, 32'h8000_0000));
    queue_item(make_item(21'd1572864, 32'hFFFF_FFFF));
    queue_item(make_item(21'h1F_FFFF, 32'd0));
    queue_item(make_item(21'h1F_FFFF, 32'h8000_0000));
    queue_item(make_item(21'h1F_FFFF, 32'hFFFF_FFFF));
    queue_item(make_item(21'h15_5555, 32'h5555_5555));
    queue_item(make_item(21'h0A_AAAA, 32'hAAAA_AAAA));
    queue_item(make_item(21'd327680, 32'hFFFF_FFF0));
    queue_item(make_item(21'd3276, 32'h0000_0001));
    wait_drained();

    // random, in three idling phases; a long receiver hold during the first
    for (int phase = 0; phase < 3; phase++) begin
      idle_mode = phase;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        case ($urandom_range(9))
          0: lam = $urandom_range(21'h1F_FFFF);
          1: lam = $urandom_range(255);
          default: lam = $urandom_range(1572864);
        endcase
        queue_item(make_item(lam[pics_pkg::LAM_W-1:0],
            ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(65535) : $urandom()));
        if (phase == 0 && i == 20) begin
          hold_receiver = 1'b1;
          repeat (2) @(posedge clk);
          hold_receiver = 1'b0;
        end
      end
      // sender pause until every result is in
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d results, %0d beyond the table, over three idling phases",
             results_seen, beyond_seen);
    $display("including a long output hold and full-range means");
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("** poisson_inverse_cdf_sampler_top: PASSED **");
    end else begin
      $display("** poisson_inverse_cdf_sampler_top: FAILED **");
    end
    $finish;
  end

endmodule
